FILE: sv/latched_chr_bank_mapper_assert.svh
// assertion macros for the latched pattern bank mapper
`ifndef LATCHED_CHR_BANK_MAPPER_ASSERT_SVH
`define LATCHED_CHR_BANK_MAPPER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clock, idle during reset
`define LCBM_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define LCBM_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define LCBM_ASSERT_IMP(label, ante, cons)
`define LCBM_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: sv/lcbm_pkg.sv
// types and constants for the latched pattern bank mapper
`timescale 1ns / 1ps
`default_nettype none

package lcbm_pkg;

   localparam int PRG_BANK_BITS = 4;
   localparam int CHR_BANK_BITS = 5;
   localparam int ADDR_BITS     = 16;
   localparam int DATA_BITS     = 8;
   localparam int OFFSET_BITS   = 18;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 5;

   typedef enum logic [1:0] {
      REQ_CPU_WRITE = 2'd0,
      REQ_CPU_READ  = 2'd1,
      REQ_PPU_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LAST_PRG_BANK   = 2'd0,
      CSR_CHR_BANK_MASK   = 2'd1,
      CSR_START_MIRRORING = 2'd2
   } csr_index_type;

   // cpu write windows, by address nibble 15:12
   localparam logic [3:0] NIB_PRG_SEL = 4'hA;
   localparam logic [3:0] NIB_MIRROR  = 4'hF;

   // ppu latch trigger lines, address bits 15:4
   localparam logic [11:0] TRIG_LOW_FD  = 12'h0FD;
   localparam logic [11:0] TRIG_LOW_FE  = 12'h0FE;
   localparam logic [11:0] TRIG_HIGH_FD = 12'h1FD;
   localparam logic [11:0] TRIG_HIGH_FE = 12'h1FE;

   localparam logic [CHR_BANK_BITS-1:0] CHR_MASK_RESET = 5'd15;

endpackage

`default_nettype wire

FILE: sv/latched_chr_bank_mapper.sv
// top level of the latched pattern bank mapper
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// req      | in        | req_valid / req_ready | req_type, req_bus_address, req_write_data
// rsp      | out       | rsp_valid / rsp_ready | mapped valid, offset, mirror, half banks
// csr      | in        | csr_wr_en             | csr_index, csr_wdata
//
// one beat in, one beat out; an accepted request shows up at rsp in the cycle after its accept
// throughput is one beat per cycle while rsp_ready holds high, set by the single rsp output register
// req_ready is high whenever the rsp register is empty or being drained this cycle
// mapper state updates at the req accept edge, so back-to-back beats see each
// other's latch and bank writes; synchronous reset, no clearing pass

module latched_chr_bank_mapper (
   input  wire                                     clock,
   input  wire                                     reset,
   // request channel
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire  [1:0]                              req_type,
   input  wire  [lcbm_pkg::ADDR_BITS-1:0]          req_bus_address,
   input  wire  [lcbm_pkg::DATA_BITS-1:0]          req_write_data,
   // response channel
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic                                    rsp_mapped_valid,
   output logic [lcbm_pkg::OFFSET_BITS-1:0]        rsp_mapped_offset,
   output logic                                    rsp_mirror_mode,
   output logic [lcbm_pkg::CHR_BANK_BITS-1:0]      rsp_low_half_bank,
   output logic [lcbm_pkg::CHR_BANK_BITS-1:0]      rsp_high_half_bank,
   // config port
   input  wire                                     csr_wr_en,
   input  wire  [lcbm_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire  [lcbm_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import lcbm_pkg::*;

   `include "latched_chr_bank_mapper_assert.svh"

   // config registers; start mirroring only ever loads the live mirroring
   logic [PRG_BANK_BITS-1:0] last_prg_ff;
   logic [CHR_BANK_BITS-1:0] chr_mask_ff;

   // mapper state
   logic [PRG_BANK_BITS-1:0] prg_sel_ff, prg_sel_in;
   logic [CHR_BANK_BITS-1:0] chr_regs_ff [4];
   logic [CHR_BANK_BITS-1:0] chr_regs_in [4];
   logic                     low_fd_ff, low_fd_in;
   logic                     high_fd_ff, high_fd_in;
   logic                     mirror_ff, mirror_in;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_mvalid_ff, rsp_mvalid_in;
   logic [OFFSET_BITS-1:0]   rsp_offset_ff, rsp_offset_in;
   logic                     rsp_mirror_ff;
   logic [CHR_BANK_BITS-1:0] rsp_low_ff, rsp_low_in;
   logic [CHR_BANK_BITS-1:0] rsp_high_ff, rsp_high_in;

   logic                     req_fire;
   logic [3:0]               addr_nib;
   logic [11:0]              addr_line;
   logic [1:0]               chr_wr_idx;
   logic [CHR_BANK_BITS-1:0] ppu_bank;
   logic                     low_fd_hit;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign addr_nib   = req_bus_address[15:12];
   assign addr_line  = req_bus_address[15:4];
   // 0xB..0xE map to registers 0..3
   assign chr_wr_idx = 2'(addr_nib[1:0] + 2'd1);
   assign low_fd_hit = req_fire && req_type == REQ_PPU_READ && addr_line == TRIG_LOW_FD;

   always_comb begin
      prg_sel_in    = prg_sel_ff;
      chr_regs_in   = chr_regs_ff;
      low_fd_in     = low_fd_ff;
      high_fd_in    = high_fd_ff;
      mirror_in     = mirror_ff;
      rsp_mvalid_in = 1'b0;
      rsp_offset_in = '0;
      ppu_bank      = '0;

      case (req_type)
         REQ_CPU_WRITE: begin
            if (addr_nib == NIB_PRG_SEL) begin
               prg_sel_in = req_write_data[PRG_BANK_BITS-1:0] & last_prg_ff;
            end else if (addr_nib == NIB_MIRROR) begin
               mirror_in = req_write_data[0];
            end else if (addr_nib > NIB_PRG_SEL) begin
               chr_regs_in[chr_wr_idx] = req_write_data[CHR_BANK_BITS-1:0] & chr_mask_ff;
            end
         end
         REQ_CPU_READ: begin
            if (req_bus_address[15]) begin
               rsp_mvalid_in = 1'b1;
               // upper window is pinned to the last bank
               rsp_offset_in = {(req_bus_address[14] ? last_prg_ff : prg_sel_ff),
                                req_bus_address[13:0]};
            end
         end
         REQ_PPU_READ: begin
            if (req_bus_address[15:13] == 3'b000) begin
               // latch first, then translate with the updated latch
               if (addr_line == TRIG_LOW_FD)       low_fd_in  = 1'b1;
               else if (addr_line == TRIG_LOW_FE)  low_fd_in  = 1'b0;
               if (addr_line == TRIG_HIGH_FD)      high_fd_in = 1'b1;
               else if (addr_line == TRIG_HIGH_FE) high_fd_in = 1'b0;
               rsp_mvalid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // banks seen after this beat's update
      rsp_low_in  = (low_fd_in  ? chr_regs_in[0] : chr_regs_in[1]) & chr_mask_ff;
      rsp_high_in = (high_fd_in ? chr_regs_in[2] : chr_regs_in[3]) & chr_mask_ff;

      if (req_type == REQ_PPU_READ && rsp_mvalid_in) begin
         ppu_bank      = req_bus_address[12] ? rsp_high_in : rsp_low_in;
         rsp_offset_in = OFFSET_BITS'({ppu_bank, req_bus_address[11:0]});
      end
   end

   // control and mapper state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_prg_ff     <= '0;
         chr_mask_ff     <= CHR_MASK_RESET;
         prg_sel_ff      <= '0;
         chr_regs_ff     <= '{default: '0};
         low_fd_ff       <= 1'b0;
         high_fd_ff      <= 1'b0;
         mirror_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            prg_sel_ff  <= prg_sel_in;
            chr_regs_ff <= chr_regs_in;
            low_fd_ff   <= low_fd_in;
            high_fd_ff  <= high_fd_in;
         end
         // a start mirroring write also reloads the live mirroring
         if (csr_wr_en && csr_index == CSR_START_MIRRORING) begin
            mirror_ff <= csr_wdata[0];
         end else if (req_fire) begin
            mirror_ff <= mirror_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LAST_PRG_BANK: last_prg_ff <= csr_wdata[PRG_BANK_BITS-1:0];
               CSR_CHR_BANK_MASK: chr_mask_ff <= csr_wdata[CHR_BANK_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // response payload, loaded on accept
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_mvalid_ff <= rsp_mvalid_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_mirror_ff <= mirror_in;
         rsp_low_ff    <= rsp_low_in;
         rsp_high_ff   <= rsp_high_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mapped_valid   = rsp_mvalid_ff;
   assign rsp_mapped_offset  = rsp_offset_ff;
   assign rsp_mirror_mode    = rsp_mirror_ff;
   assign rsp_low_half_bank  = rsp_low_ff;
   assign rsp_high_half_bank = rsp_high_ff;

   `LCBM_ASSERT_NXT(a_fire_gives_rsp, req_fire, rsp_valid_ff)
   `LCBM_ASSERT_IMP(a_no_overwrite, rsp_valid_ff && !rsp_ready, !req_ready)
   `LCBM_ASSERT_NXT(a_low_fd_trigger, low_fd_hit, low_fd_ff)
   `LCBM_ASSERT_IMP(a_unmapped_zero, rsp_valid_ff && !rsp_mvalid_ff, rsp_offset_ff == '0)

endmodule

`default_nettype wire

FILE: dv/tb_latched_chr_bank_mapper.sv
// testbench for the latched pattern bank mapper: random and directed accesses checked beat by beat
`timescale 1ns / 1ps

module tb_latched_chr_bank_mapper;
   import lcbm_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 300;     // long receiver back-off
   localparam int REPORT_LIMIT = 10;
   localparam int PHASE_ITEMS  = 140;
   localparam int NUM_PHASES   = 7;
   localparam int DRAIN_CYCLES = 3;       // margin before the final check

   // request type code that the block treats as no access
   localparam logic [1:0] REQ_NO_ACCESS = 2'd3;
   // first cpu write window of the pattern bank registers
   localparam logic [3:0] NIB_CHR_FIRST = 4'hB;
   localparam logic [15:0] CPU_ROM_BASE   = 16'h8000;
   localparam logic [15:0] CPU_FIXED_BASE = 16'hC000;
   localparam logic [15:0] PPU_LIMIT      = 16'h2000;

   typedef struct packed {
      logic [1:0]           kind;
      logic [ADDR_BITS-1:0] addr;
      logic [DATA_BITS-1:0] data;
   } bus_access_t;

   typedef struct packed {
      logic                     valid;
      logic [OFFSET_BITS-1:0]   offset;
      logic                     mirror;
      logic [CHR_BANK_BITS-1:0] low_bank;
      logic [CHR_BANK_BITS-1:0] high_bank;
   } mapping_t;

   // ---------------------------------------------------------------- dut hookup
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid       = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_type        = '0;
   logic [ADDR_BITS-1:0]       req_bus_address = '0;
   logic [DATA_BITS-1:0]       req_write_data  = '0;

   logic                       rsp_valid;
   logic                       rsp_ready       = 1'b1;
   logic                       rsp_mapped_valid;
   logic [OFFSET_BITS-1:0]     rsp_mapped_offset;
   logic                       rsp_mirror_mode;
   logic [CHR_BANK_BITS-1:0]   rsp_low_half_bank;
   logic [CHR_BANK_BITS-1:0]   rsp_high_half_bank;

   logic                       csr_wr_en       = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index       = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata       = '0;

   latched_chr_bank_mapper u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_bus_address    (req_bus_address),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_mapped_valid   (rsp_mapped_valid),
      .rsp_mapped_offset  (rsp_mapped_offset),
      .rsp_mirror_mode    (rsp_mirror_mode),
      .rsp_low_half_bank  (rsp_low_half_bank),
      .rsp_high_half_bank (rsp_high_half_bank),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- mapper prediction
   // config copy
   logic [PRG_BANK_BITS-1:0] cfg_last_prg;
   logic [CHR_BANK_BITS-1:0] cfg_chr_mask;
   // mapper state copy
   logic [PRG_BANK_BITS-1:0] prg_sel_q;
   logic [CHR_BANK_BITS-1:0] chr_bank_q [4];
   logic                     low_fd_q;
   logic                     high_fd_q;
   logic                     mirror_q;

   bus_access_t pending_accesses [$];  // items not yet offered on req
   mapping_t    mapping_due [$];       // expected rsp beats, oldest first
   int          fail_count = 0;
   int          hold_seq   = 0;        // bumped to ask the receiver for a long back-off

   function automatic void reset_mapper_copy();
      cfg_last_prg     = '0;
      cfg_chr_mask     = CHR_MASK_RESET;
      prg_sel_q        = '0;
      for (int i = 0; i < 4; i++) chr_bank_q[i] = '0;
      low_fd_q         = 1'b0;
      high_fd_q        = 1'b0;
      mirror_q         = 1'b0;
   endfunction

   // bank mapped at one pattern half, picked by that half's latch
   function automatic logic [CHR_BANK_BITS-1:0] live_bank(logic upper);
      logic [CHR_BANK_BITS-1:0] r;
      if (upper) r = high_fd_q ? chr_bank_q[2] : chr_bank_q[3];
      else       r = low_fd_q  ? chr_bank_q[0] : chr_bank_q[1];
      return r & cfg_chr_mask;
   endfunction

   // apply one access to the state copy and return the beat it should produce
   function automatic mapping_t apply_access(bus_access_t a);
      mapping_t                 m;
      logic [3:0]               nib;
      logic [1:0]               ridx;
      logic [PRG_BANK_BITS-1:0] bank;
      m   = '0;
      nib = a.addr[15:12];
      case (a.kind)
         REQ_CPU_WRITE: begin
            if (nib == NIB_PRG_SEL) begin
               prg_sel_q = a.data[PRG_BANK_BITS-1:0] & cfg_last_prg;
            end else if (nib >= NIB_CHR_FIRST && nib < NIB_MIRROR) begin
               ridx = 2'(nib - NIB_CHR_FIRST);
               chr_bank_q[ridx] = a.data[CHR_BANK_BITS-1:0] & cfg_chr_mask;
            end else if (nib == NIB_MIRROR) begin
               mirror_q = a.data[0];
            end
         end
         REQ_CPU_READ: begin
            if (a.addr >= CPU_ROM_BASE) begin
               // upper window is pinned to the last program bank
               bank     = (a.addr >= CPU_FIXED_BASE) ? cfg_last_prg : prg_sel_q;
               m.valid  = 1'b1;
               m.offset = {bank, a.addr[13:0]};
            end
         end
         REQ_PPU_READ: begin
            if (a.addr < PPU_LIMIT) begin
               // latch moves first, then the same read is translated
               case (a.addr[15:4])
                  TRIG_LOW_FD:  low_fd_q  = 1'b1;
                  TRIG_LOW_FE:  low_fd_q  = 1'b0;
                  TRIG_HIGH_FD: high_fd_q = 1'b1;
                  TRIG_HIGH_FE: high_fd_q = 1'b0;
                  default: ;
               endcase
               m.valid  = 1'b1;
               m.offset = {1'b0, live_bank(a.addr[12]), a.addr[11:0]};
            end
         end
         default: ;  // no access, nothing moves
      endcase
      m.mirror    = mirror_q;
      m.low_bank  = live_bank(1'b0);
      m.high_bank = live_bank(1'b1);
      return m;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic void queue_access(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
      bus_access_t a;
      a.kind = kind;
      a.addr = addr;
      a.data = data;
      pending_accesses.push_back(a);
   endfunction

   // mostly meaningful accesses: register writes, rom reads, pattern reads near triggers
   function automatic bus_access_t random_access();
      bus_access_t a;
      int          pick;
      int          sub;
      logic [11:0] line;
      pick   = $urandom_range(0, 99);
      sub    = $urandom_range(0, 9);
      a.data = 8'($urandom_range(0, 255));
      a.addr = 16'($urandom);
      if (pick < 30) begin
         a.kind = REQ_CPU_WRITE;
         // mostly the register windows, sometimes anywhere
         if (sub != 0) a.addr[15:12] = 4'($urandom_range(int'(NIB_PRG_SEL), int'(NIB_MIRROR)));
      end else if (pick < 55) begin
         a.kind = REQ_CPU_READ;
         if (sub > 1) a.addr[15] = 1'b1;
      end else if (pick < 95) begin
         a.kind = REQ_PPU_READ;
         if (sub >= 1 && sub <= 4) begin
            case ($urandom_range(0, 3))
               0: line = TRIG_LOW_FD;
               1: line = TRIG_LOW_FE;
               2: line = TRIG_HIGH_FD;
               default: line = TRIG_HIGH_FE;
            endcase
            a.addr = {line, 4'($urandom_range(0, 15))};
         end else if (sub > 4) begin
            a.addr[15:13] = 3'b000;
         end
      end else begin
         a.kind = REQ_NO_ACCESS;
      end
      return a;
   endfunction

   // registers change only while the mapper has nothing in flight
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LAST_PRG_BANK: cfg_last_prg = value[PRG_BANK_BITS-1:0];
         CSR_CHR_BANK_MASK: cfg_chr_mask = value;
         CSR_START_MIRRORING: mirror_q = value[0];  // also reloads live mirroring
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // sampled on the falling edge so the driver's updates at the rising edge have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_accesses.size() != 0 || req_valid || mapping_due.size() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------- request driver
   // bursts of back-to-back beats separated by random gaps
   always @(posedge clock) begin : req_driver
      logic        valid_next;
      int          burst_left;
      int          gap_left;
      bus_access_t on_bus;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         valid_next = req_valid;
         // a beat accepted at this edge updates the mapper copy right here
         if (req_valid && req_ready) begin
            mapping_due.push_back(apply_access(on_bus));
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_accesses.size() != 0) begin
               on_bus = pending_accesses.pop_front();
               req_type        <= on_bus.kind;
               req_bus_address <= on_bus.addr;
               req_write_data  <= on_bus.data;
               valid_next = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= valid_next;
      end
   end

   // ---------------------------------------------------------------- response side
   // stall mode is re-drawn at random; a hold request forces a long back-off
   always @(posedge clock) begin : rsp_sink
      int   hold_seen;
      int   hold_left;
      int   mode_cycles;
      int   sink_mode;
      logic ready_next;
      if (reset) begin
         hold_seen   = 0;
         hold_left   = 0;
         mode_cycles = 0;
         sink_mode   = 0;
         rsp_ready   <= 1'b1;
      end else begin
         if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         mode_cycles++;
         if (mode_cycles % 64 == 0) sink_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (sink_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = ($urandom_range(0, 3) != 0);
               default: ready_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= ready_next;
      end
   end

   // compare every accepted rsp beat with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      mapping_t seen;
      mapping_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_mapped_valid, rsp_mapped_offset, rsp_mirror_mode,
                 rsp_low_half_bank, rsp_high_half_bank};
         if (mapping_due.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: rsp beat with nothing expected: valid=%0d off=%h mir=%0d lo=%0d hi=%0d",
                        $realtime, seen.valid, seen.offset, seen.mirror, seen.low_bank,
                        seen.high_bank);
         end else begin
            want = mapping_due.pop_front();
            if (seen !== want) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t: rsp mismatch: exp valid=%0d off=%h mir=%0d lo=%0d hi=%0d",
                           $realtime, want.valid, want.offset, want.mirror, want.low_bank,
                           want.high_bank);
                  $display("   got valid=%0d off=%h mir=%0d lo=%0d hi=%0d",
                           seen.valid, seen.offset, seen.mirror, seen.low_bank,
                           seen.high_bank);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      int cycle_count;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin : test_sequence
      logic [CSR_DATA_BITS-1:0] last_val;
      logic [CSR_DATA_BITS-1:0] mask_val;
      logic [CSR_DATA_BITS-1:0] mirror_val;
      reset_mapper_copy();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // full-width config so bank numbers are visible
      csr_write(CSR_LAST_PRG_BANK, 5'd15);
      csr_write(CSR_CHR_BANK_MASK, 5'd31);
      csr_write(CSR_START_MIRRORING, 5'd1);

      // mirroring writes at both ends of the window
      queue_access(REQ_CPU_WRITE, 16'hF000, 8'h00);
      queue_access(REQ_CPU_WRITE, 16'hFFFF, 8'hFF);
      // program select, then writes that must be ignored
      queue_access(REQ_CPU_WRITE, 16'hA000, 8'hFF);
      queue_access(REQ_CPU_WRITE, 16'h9FFF, 8'h55);
      queue_access(REQ_CPU_WRITE, 16'h0000, 8'hFF);
      // all four pattern bank registers
      queue_access(REQ_CPU_WRITE, 16'hB000, 8'hFF);
      queue_access(REQ_CPU_WRITE, 16'hC000, 8'h0A);
      queue_access(REQ_CPU_WRITE, 16'hD000, 8'h15);
      queue_access(REQ_CPU_WRITE, 16'hEFFF, 8'h1E);
      // cpu reads: no rom below 0x8000, switchable window, fixed window
      queue_access(REQ_CPU_READ, 16'h0000, 8'h00);
      queue_access(REQ_CPU_READ, 16'h7FFF, 8'hFF);
      queue_access(REQ_CPU_READ, 16'h8000, 8'h00);
      queue_access(REQ_CPU_READ, 16'hBFFF, 8'h00);
      queue_access(REQ_CPU_READ, 16'hC000, 8'h00);
      queue_access(REQ_CPU_READ, 16'hFFFF, 8'h00);
      // latch trigger ranges, each hit at one of its edges
      queue_access(REQ_PPU_READ, 16'h0FD0, 8'h00);
      queue_access(REQ_PPU_READ, 16'h0FE0, 8'h00);
      queue_access(REQ_PPU_READ, 16'h0FDF, 8'h00);
      queue_access(REQ_PPU_READ, 16'h1FD0, 8'h00);
      queue_access(REQ_PPU_READ, 16'h1FEF, 8'h00);
      // plain pattern reads and reads outside pattern space
      queue_access(REQ_PPU_READ, 16'h0000, 8'h00);
      queue_access(REQ_PPU_READ, 16'h1FFF, 8'h00);
      queue_access(REQ_PPU_READ, 16'h2000, 8'h00);
      queue_access(REQ_PPU_READ, 16'hFFFF, 8'h00);
      // unused request code
      queue_access(REQ_NO_ACCESS, 16'hFFFF, 8'hFF);
      wait_drained();

      // random phases, each under its own config; sender pauses at every boundary
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin last_val = 5'd0;  mask_val = 5'd0;  mirror_val = 5'd0; end
            1: begin last_val = 5'd15; mask_val = 5'd31; mirror_val = 5'd0; end
            2: begin last_val = 5'd7;  mask_val = 5'd15; mirror_val = 5'd1; end
            4: begin last_val = 5'd3;  mask_val = 5'd16; mirror_val = 5'd1; end
            6: begin last_val = 5'd15; mask_val = 5'd15; mirror_val = 5'd0; end
            default: begin
               last_val   = 5'($urandom_range(0, 15));
               mask_val   = 5'($urandom_range(0, 31));
               mirror_val = 5'($urandom_range(0, 1));
            end
         endcase
         csr_write(CSR_LAST_PRG_BANK, last_val);
         csr_write(CSR_CHR_BANK_MASK, mask_val);
         csr_write(CSR_START_MIRRORING, mirror_val);
         // long receiver back-off so req_ready drops while items keep coming
         if (phase == 1 || phase == 4) hold_seq <= hold_seq + 1;
         repeat (PHASE_ITEMS) pending_accesses.push_back(random_access());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && mapping_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/lcbm_pkg.sv
sv/latched_chr_bank_mapper.sv
dv/tb_latched_chr_bank_mapper.sv
